>>> hdl/sfrs_pkg.sv
// sfrs_pkg: shared constants, types and saturating helpers for the
// sediment flux routing step. No dependencies.
`default_nettype none
package sfrs_pkg;
    localparam int unsigned VW = 48;
    localparam int unsigned AW = 47;
    // number of grid cells; a 16-bit index covers them all
    localparam int unsigned CELLS = 65536;
    localparam int unsigned IW = 16;
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [AW-1:0] AREA_RST = 47'd58982400;

    typedef logic signed [VW-1:0] t_val;

    // saturate a 49-bit signed sum to 48 bits
    function automatic t_val sat49(input logic signed [VW:0] v);
        t_val r;
        if (v[VW] != v[VW-1]) begin
            r = v[VW] ? VMIN : VMAX;
        end else begin
            r = v[VW-1:0];
        end
        return r;
    endfunction

    function automatic t_val sadd(input t_val a, input t_val b);
        return sat49({a[VW-1], a} + {b[VW-1], b});
    endfunction

    function automatic t_val ssub(input t_val a, input t_val b);
        return sat49({a[VW-1], a} - {b[VW-1], b});
    endfunction

    function automatic t_val sneg(input t_val a);
        return sat49(-{a[VW-1], a});
    endfunction

    // magnitude with sign applied, saturated
    function automatic t_val apply_sign(input logic [VW:0] m, input logic neg);
        t_val r;
        if (neg) begin
            r = (m >= (49'd1 << 47)) ? VMIN : t_val'(-m[VW-1:0]);
        end else begin
            r = (m > 49'h7FFF_FFFF_FFFF) ? VMAX : t_val'(m[VW-1:0]);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

>>> hdl/sfrs_ram.sv
// sfrs_ram: generic single-port-write, single-read ram with registered read.
// No dependencies.
`default_nettype none
module sfrs_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 65536
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/sfrs_muldiv.sv
// sfrs_muldiv: shared iterative unit for signed x cell area (shift-add, one
// bit a cycle) and signed / cell area (restoring, one bit a cycle). Uses sfrs_pkg.
`default_nettype none
module sfrs_muldiv (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire                      i_div,
    input  wire [47:0]               i_a,
    input  wire [46:0]               i_area,
    output logic                     o_done,
    output logic [47:0]              o_res
);
    localparam int unsigned STEPS = 64;
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_END} t_st;
    t_st r_st;
    logic [6:0]   r_cnt;
    logic         r_div, r_neg, r_zero;
    logic [63:0]  r_q;      // dividend shift / quotient, or multiplier bits
    logic [64:0]  r_rem;    // remainder of the restoring division
    logic [95:0]  r_acc;
    logic [46:0]  r_area;
    logic [47:0]  r_res;
    logic [47:0]  w_mag;
    logic [65:0]  w_trial;

    assign w_mag = i_a[47] ? 48'(-i_a) : i_a;
    assign w_trial = {r_rem, r_q[63]} - {19'd0, r_area};
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_div <= i_div;
                        r_neg <= i_a[47];
                        r_zero <= (i_a == '0);
                        r_area <= i_area;
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_acc <= '0;
                        r_q <= i_div ? {w_mag, 16'd0} : {16'd0, w_mag};
                        r_st <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_div) begin
                        if (!w_trial[65]) begin
                            r_rem <= w_trial[64:0];
                            r_q <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[63:0], r_q[63]};
                            r_q <= {r_q[62:0], 1'b0};
                        end
                    end else begin
                        if (r_q[0]) begin
                            r_acc <= r_acc + ({49'd0, r_area} << r_cnt[5:0]);
                        end
                        r_q <= {1'b0, r_q[63:1]};
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(STEPS - 1)) begin
                        r_st <= S_END;
                    end
                end
                S_END: begin
                    if (r_div) begin
                        if (r_area == '0) begin
                            // zero area: saturate toward the dividend's sign, zero dividend gives zero
                            r_res <= r_zero ? '0 : (r_neg ? sfrs_pkg::VMIN
                                                          : sfrs_pkg::VMAX);
                        end else begin
                            r_res <= sfrs_pkg::apply_sign(
                                (r_q[63:48] != '0) ? 49'h1_0000_0000_0000
                                                   : {1'b0, r_q[47:0]}, r_neg);
                        end
                    end else begin
                        r_res <= sfrs_pkg::apply_sign(
                            (r_acc[95:63] != '0) ? 49'h1_0000_0000_0000
                                                 : {1'b0, r_acc[63:16]}, r_neg);
                    end
                    o_done <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/sediment_flux_routing_step.sv
// Sediment flux routing step. Cells come in descending elevation order, one request at
// a time, and each gives one result while two accumulator memories (cell inflow and
// basin-outlet inflow) are updated. After reset the block clears both memories, one
// entry a cycle, before it accepts a request. Each request makes one to five passes
// through one shared 64-step multiply/divide unit by the cell area, plus memory access
// and the output handshake, and the next request is accepted only after the result is
// taken. A hillslope cell without sediment clamp is the shortest, a detachment-limited
// cell whose sediment clamp applies the longest. Configuration writes are taken at any
// time but belong between requests.
// Uses sfrs_pkg, sfrs_ram, sfrs_muldiv.
`default_nettype none
module sediment_flux_routing_step (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [46:0]  i_cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // cell_index, dest_index, dest_is_basin, is_basin_outlet, basin_capacity,
    // is_hillslope, carry_capacity, incision_volume, bed_sediment,
    // sediment_depth, bedrock_height, bedrock_height_downstream (+5 zero bits)
    input  wire  [375:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_cell, d_sediment, d_bedrock, d_bed_sediment, out_flux, in_flux,
    // basin_inflow, basin_filled (+7 zero bits)
    output logic [311:0] m_axis_tdata
);
    localparam int unsigned IW = sfrs_pkg::IW;
    typedef logic signed [47:0] t_v;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_RD, S_RDW, S_OUTLET, S_BR, S_HDIV, S_HCHK, S_HMUL,
        S_TDIV, S_TMUL, S_DDIV, S_DCLAMP, S_DMUL1, S_DDIV2, S_DCHK, S_DMUL2,
        S_DMUL3, S_ACCRD, S_ACCRW, S_ACCWR, S_OUT
    } t_st;
    t_st r_st;

    logic [46:0] r_area;
    logic [IW:0] r_clr;
    logic [IW-1:0] r_cidx, r_didx;
    logic [15:0] r_cell;
    logic r_tob, r_outlet, r_hill, r_filled;
    t_v r_cap, r_carry, r_incis, r_bed, r_depth, r_bh, r_bhd;
    t_v r_inflow, r_binflow, r_ds, r_db, r_dbs, r_oflux, r_supply;

    logic        r_mstart, r_mdiv;
    t_v          r_ma;
    logic        w_mdone;
    logic [47:0] w_mres;

    logic        w_iwe, w_bwe;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [47:0] w_wdata, w_irdata, w_brdata;

    // basin overflow at an outlet
    logic        w_fill;
    t_v          w_over;

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_st == S_IDLE);
    assign w_fill = r_outlet && (r_binflow > r_cap);
    assign w_over = sfrs_pkg::sadd(r_inflow, sfrs_pkg::ssub(r_binflow, r_cap));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= sfrs_pkg::AREA_RST;
        end else if (i_cfg_valid) begin
            r_area <= i_cfg_data;
        end
    end

    sfrs_muldiv u_md (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart), .i_div(r_mdiv),
        .i_a(r_ma), .i_area(r_area), .o_done(w_mdone), .o_res(w_mres)
    );

    always_comb begin
        w_iwe = 1'b0;
        w_bwe = 1'b0;
        w_waddr = r_cidx;
        w_wdata = r_inflow;
        w_raddr = (r_st == S_ACCRD || r_st == S_ACCRW) ? r_didx : r_cidx;
        unique case (r_st)
            S_CLR: begin
                w_iwe = 1'b1;
                w_bwe = 1'b1;
                w_waddr = r_clr[IW-1:0];
                w_wdata = '0;
            end
            S_OUTLET: begin
                w_iwe = w_fill;
                w_wdata = w_over;
            end
            S_ACCWR: begin
                w_waddr = r_didx;
                w_wdata = sfrs_pkg::sadd(r_tob ? w_brdata : w_irdata, r_oflux);
                w_iwe = !r_tob;
                w_bwe = r_tob;
            end
            default: ;
        endcase
    end

    sfrs_ram #(.WIDTH(48), .DEPTH(sfrs_pkg::CELLS)) u_in (
        .i_clk(i_clk), .i_we(w_iwe), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_irdata)
    );
    sfrs_ram #(.WIDTH(48), .DEPTH(sfrs_pkg::CELLS)) u_bs (
        .i_clk(i_clk), .i_we(w_bwe), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_brdata)
    );

    assign m_axis_tdata = {7'd0, r_filled, r_binflow, r_inflow, r_oflux, r_dbs,
                           r_db, r_ds, r_cell};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_clr <= '0;
            r_mstart <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (IW+1)'(sfrs_pkg::CELLS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cell <= s_axis_tdata[15:0];
                        r_cidx <= s_axis_tdata[IW-1:0];
                        r_didx <= s_axis_tdata[16 +: IW];
                        r_tob <= s_axis_tdata[32];
                        r_outlet <= s_axis_tdata[33];
                        r_cap <= s_axis_tdata[81:34];
                        r_hill <= s_axis_tdata[82];
                        r_carry <= s_axis_tdata[130:83];
                        r_incis <= s_axis_tdata[178:131];
                        r_bed <= s_axis_tdata[226:179];
                        r_depth <= s_axis_tdata[274:227];
                        r_bh <= s_axis_tdata[322:275];
                        r_bhd <= s_axis_tdata[370:323];
                        r_st <= S_RD;
                    end
                end
                S_RD: begin
                    r_st <= S_RDW;
                end
                S_RDW: begin
                    r_inflow <= w_irdata;
                    r_binflow <= w_brdata;
                    r_filled <= 1'b0;
                    r_db <= '0;
                    r_dbs <= '0;
                    r_st <= S_OUTLET;
                end
                S_OUTLET: begin
                    if (w_fill) begin
                        r_inflow <= w_over;
                        r_filled <= 1'b1;
                    end
                    r_st <= S_BR;
                end
                S_BR: begin
                    r_mstart <= 1'b1;
                    r_mdiv <= 1'b1;
                    if (r_hill) begin
                        r_oflux <= r_carry;
                        r_ma <= sfrs_pkg::ssub(r_inflow, r_carry);
                        r_st <= S_HDIV;
                    end else if (sfrs_pkg::ssub(r_carry, r_inflow) <= r_bed) begin
                        r_oflux <= r_carry;
                        r_ma <= sfrs_pkg::ssub(r_inflow, r_carry);
                        r_st <= S_TDIV;
                    end else begin
                        r_supply <= sfrs_pkg::sadd(r_inflow, r_bed);
                        r_ma <= r_incis;
                        r_st <= S_DDIV;
                    end
                end
                S_HDIV: if (w_mdone) begin
                    r_ds <= t_v'(w_mres);
                    r_st <= S_HCHK;
                end
                S_HCHK: begin
                    if (($signed({r_depth[47], r_depth}) + $signed({r_ds[47], r_ds}))
                            < 0) begin
                        r_ds <= sfrs_pkg::sneg(r_depth);
                        r_ma <= r_depth;
                        r_mdiv <= 1'b0;
                        r_mstart <= 1'b1;
                        r_st <= S_HMUL;
                    end else begin
                        r_st <= S_ACCRD;
                    end
                end
                S_HMUL: if (w_mdone) begin
                    r_oflux <= t_v'(w_mres);
                    r_st <= S_ACCRD;
                end
                S_TDIV: if (w_mdone) begin
                    r_ds <= t_v'(w_mres);
                    r_ma <= t_v'(w_mres);
                    r_mdiv <= 1'b0;
                    r_mstart <= 1'b1;
                    r_st <= S_TMUL;
                end
                S_TMUL: if (w_mdone && !r_mstart) begin
                    r_dbs <= t_v'(w_mres);
                    r_st <= S_ACCRD;
                end
                S_DDIV: if (w_mdone) begin
                    r_db <= sfrs_pkg::sneg(t_v'(w_mres));
                    r_st <= S_DCLAMP;
                end
                S_DCLAMP: begin
                    if (($signed({r_bh[47], r_bh}) + $signed({r_db[47], r_db}))
                            < $signed({r_bhd[47], r_bhd})) begin
                        if (sfrs_pkg::ssub(r_bhd, r_bh) > 0) begin
                            r_db <= '0;
                            r_ma <= '0;
                        end else begin
                            r_db <= sfrs_pkg::ssub(r_bhd, r_bh);
                            r_ma <= sfrs_pkg::ssub(r_bhd, r_bh);
                        end
                    end else begin
                        r_ma <= r_db;
                    end
                    r_mdiv <= 1'b0;
                    r_mstart <= 1'b1;
                    r_st <= S_DMUL1;
                end
                S_DMUL1: if (w_mdone && !r_mstart) begin
                    r_oflux <= sfrs_pkg::ssub(r_supply, t_v'(w_mres));
                    r_ma <= r_supply;
                    r_mdiv <= 1'b1;
                    r_mstart <= 1'b1;
                    r_st <= S_DDIV2;
                end
                S_DDIV2: if (w_mdone && !r_mstart) begin
                    r_ds <= sfrs_pkg::sneg(t_v'(w_mres));
                    r_st <= S_DCHK;
                end
                S_DCHK: begin
                    r_mdiv <= 1'b0;
                    r_mstart <= 1'b1;
                    if (($signed({r_depth[47], r_depth}) + $signed({r_ds[47], r_ds}))
                            < 0) begin
                        r_ds <= sfrs_pkg::sneg(r_depth);
                        r_ma <= sfrs_pkg::sadd(sfrs_pkg::sneg(r_depth), r_db);
                        r_st <= S_DMUL2;
                    end else begin
                        r_ma <= r_ds;
                        r_st <= S_DMUL3;
                    end
                end
                S_DMUL2: if (w_mdone && !r_mstart) begin
                    r_oflux <= sfrs_pkg::sneg(t_v'(w_mres));
                    r_ma <= r_ds;
                    r_mstart <= 1'b1;
                    r_st <= S_DMUL3;
                end
                S_DMUL3: if (w_mdone && !r_mstart) begin
                    r_dbs <= t_v'(w_mres);
                    r_st <= S_ACCRD;
                end
                S_ACCRD: r_st <= S_ACCRW;
                S_ACCRW: r_st <= S_ACCWR;
                S_ACCWR: begin
                    m_axis_tvalid <= 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sim/testbench.sv
// Regression for sediment_flux_routing_step: directed and randomised cell requests are checked
// against a behavioural model of the routing accumulators and erosion rates.
// Depends on sfrs_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;
    localparam longint LIMIT = 2_000_000;

    typedef struct packed {
        logic [15:0] idx;
        logic [15:0] dest;
        logic to_basin;
        logic outlet;
        sfrs_pkg::t_val cap;
        logic hill;
        sfrs_pkg::t_val carry;
        sfrs_pkg::t_val incis;
        sfrs_pkg::t_val bed;
        sfrs_pkg::t_val depth;
        sfrs_pkg::t_val bh;
        sfrs_pkg::t_val bhd;
    } t_cell_req;

    typedef struct packed {
        logic [15:0] idx;
        sfrs_pkg::t_val ds;
        sfrs_pkg::t_val db;
        sfrs_pkg::t_val dbs;
        sfrs_pkg::t_val oflux;
        sfrs_pkg::t_val influx;
        sfrs_pkg::t_val binflow;
        logic filled;
    } t_cell_res;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic [46:0] i_cfg_data = '0;
    logic s_axis_tvalid = 0;
    logic [375:0] s_axis_tdata = '0;
    logic m_axis_tready = 0;
    wire o_cfg_ready, s_axis_tready, m_axis_tvalid;
    wire [311:0] m_axis_tdata;

    sediment_flux_routing_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // model state
    sfrs_pkg::t_val inflow_acc [sfrs_pkg::CELLS];
    sfrs_pkg::t_val basin_acc [sfrs_pkg::CELLS];
    logic [46:0] area;
    t_cell_res pending_res[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 0;
    longint cycles = 0;

    function automatic logic [48:0] mag_of(sfrs_pkg::t_val a);
        return a[47] ? 49'(-{a[47], a}) : {1'b0, a};
    endfunction

    function automatic sfrs_pkg::t_val times_area(sfrs_pkg::t_val a);
        logic [95:0] p;
        logic [48:0] r;
        p = 96'(mag_of(a)) * 96'(area);
        if (p[95:63] != 0) r = 49'd1 << 48;
        else r = 49'(p[63:16]);
        return sfrs_pkg::apply_sign(r, a[47]);
    endfunction

    function automatic sfrs_pkg::t_val per_area(sfrs_pkg::t_val a);
        logic [95:0] q;
        if (area == 0) begin
            return a[47] ? sfrs_pkg::VMIN : (a == 0 ? '0 : sfrs_pkg::VMAX);
        end
        q = (96'(mag_of(a)) << 16) / 96'(area);
        return sfrs_pkg::apply_sign((q[95:48] != 0) ? 49'd1 << 48 : {1'b0, q[47:0]},
                                    a[47]);
    endfunction

    function automatic logic [49:0] wide(sfrs_pkg::t_val a);
        return {{2{a[47]}}, a};
    endfunction

    function automatic t_cell_res route_cell(t_cell_req r);
        t_cell_res o;
        sfrs_pkg::t_val inflow, binflow, ds, db, dbs, oflux, supply;
        logic [15:0] c, d;
        // 16-bit indices already lie inside the 65536 cells
        c = r.idx;
        d = r.dest;
        inflow = inflow_acc[c];
        binflow = basin_acc[c];
        ds = 0; db = 0; dbs = 0;
        o.filled = 0;
        if (r.outlet && binflow > r.cap) begin
            inflow = sfrs_pkg::sadd(inflow, sfrs_pkg::ssub(binflow, r.cap));
            inflow_acc[c] = inflow;
            o.filled = 1;
        end
        if (r.hill) begin
            oflux = r.carry;
            ds = per_area(sfrs_pkg::ssub(inflow, oflux));
            if ($signed(wide(r.depth) + wide(ds)) < 0) begin
                ds = sfrs_pkg::sneg(r.depth);
                oflux = times_area(r.depth);
            end
        end else if (sfrs_pkg::ssub(r.carry, inflow) <= r.bed) begin
            oflux = r.carry;
            ds = per_area(sfrs_pkg::ssub(inflow, oflux));
            dbs = times_area(ds);
        end else begin
            supply = sfrs_pkg::sadd(inflow, r.bed);
            db = sfrs_pkg::sneg(per_area(r.incis));
            if ($signed(wide(r.bh) + wide(db)) < $signed(wide(r.bhd))) begin
                db = sfrs_pkg::ssub(r.bhd, r.bh);
                if (db > 0) db = 0;
            end
            oflux = sfrs_pkg::ssub(supply, times_area(db));
            ds = sfrs_pkg::sneg(per_area(supply));
            if ($signed(wide(r.depth) + wide(ds)) < 0) begin
                ds = sfrs_pkg::sneg(r.depth);
                oflux = sfrs_pkg::sneg(times_area(sfrs_pkg::sadd(ds, db)));
            end
            dbs = times_area(ds);
        end
        if (r.to_basin) basin_acc[d] = sfrs_pkg::sadd(basin_acc[d], oflux);
        else inflow_acc[d] = sfrs_pkg::sadd(inflow_acc[d], oflux);
        o.idx = r.idx;
        o.ds = ds; o.db = db; o.dbs = dbs;
        o.oflux = oflux; o.influx = inflow; o.binflow = binflow;
        return o;
    endfunction

    function automatic logic [375:0] pack_req(t_cell_req r);
        return {5'b0, r.bhd, r.bh, r.depth, r.bed, r.incis, r.carry, r.hill,
                r.cap, r.outlet, r.to_basin, r.dest, r.idx};
    endfunction

    // tvalid stays up between back-to-back requests and drops only when idling
    task automatic send_cell(t_cell_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= pack_req(r);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_res.push_back(route_cell(r));
    endtask

    task automatic write_area(logic [46:0] v);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        area = v;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_cell_res got, exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.idx = m_axis_tdata[15:0];
            got.ds = m_axis_tdata[63:16];
            got.db = m_axis_tdata[111:64];
            got.dbs = m_axis_tdata[159:112];
            got.oflux = m_axis_tdata[207:160];
            got.influx = m_axis_tdata[255:208];
            got.binflow = m_axis_tdata[303:256];
            got.filled = m_axis_tdata[304];
            if (pending_res.size() == 0) begin
                $error("result for cell %0d with none expected", got.idx);
                errors++;
            end else begin
                exp_res = pending_res.pop_front();
                if (got.idx !== exp_res.idx) begin
                    $error("out_cell exp %0d got %0d", exp_res.idx, got.idx); errors++;
                end
                if (got.ds !== exp_res.ds) begin
                    $error("d_sediment exp %0d got %0d", exp_res.ds, got.ds); errors++;
                end
                if (got.db !== exp_res.db) begin
                    $error("d_bedrock exp %0d got %0d", exp_res.db, got.db); errors++;
                end
                if (got.dbs !== exp_res.dbs) begin
                    $error("d_bed_sediment exp %0d got %0d", exp_res.dbs, got.dbs);
                    errors++;
                end
                if (got.oflux !== exp_res.oflux) begin
                    $error("out_flux exp %0d got %0d", exp_res.oflux, got.oflux); errors++;
                end
                if (got.influx !== exp_res.influx) begin
                    $error("in_flux exp %0d got %0d", exp_res.influx, got.influx); errors++;
                end
                if (got.binflow !== exp_res.binflow) begin
                    $error("basin_inflow exp %0d got %0d", exp_res.binflow, got.binflow);
                    errors++;
                end
                if (got.filled !== exp_res.filled) begin
                    $error("basin_filled exp %0d got %0d", exp_res.filled, got.filled);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("sediment_flux_routing_step regression: fail");
            $finish;
        end
    end

    // values biased toward extremes and small magnitudes
    function automatic sfrs_pkg::t_val pick_val();
        case ($urandom_range(7))
            0: return sfrs_pkg::VMAX;
            1: return sfrs_pkg::VMIN;
            2: return '0;
            3: return sfrs_pkg::t_val'({$urandom, $urandom});
            default: return sfrs_pkg::t_val'($signed($urandom_range(2000000)))
                            - sfrs_pkg::t_val'(1000000) <<< 8;
        endcase
    endfunction

    // few cells so accumulators are revisited often
    function automatic t_cell_req rand_cell(int span);
        t_cell_req r;
        r.idx = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(span));
        r.dest = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(span));
        r.to_basin = 1'($urandom_range(1));
        r.outlet = 1'($urandom_range(1));
        r.cap = pick_val();
        r.hill = 1'($urandom_range(1));
        r.carry = pick_val();
        r.incis = pick_val();
        r.bed = pick_val();
        r.depth = pick_val();
        r.bh = pick_val();
        r.bhd = pick_val();
        return r;
    endfunction

    task automatic test_directed();
        t_cell_req r;
        // hillslope, transport-limited, detachment-limited on default area
        r = '{idx: 16'd0, dest: 16'd1, to_basin: 1'b0, outlet: 1'b0, cap: '0,
              hill: 1'b1, carry: 48'sd65536, incis: '0, bed: '0, depth: 48'sd100000,
              bh: '0, bhd: '0};
        send_cell(r);
        r.hill = 0; r.idx = 16'd1; r.dest = 16'd2; r.bed = sfrs_pkg::VMAX;
        send_cell(r);
        r.idx = 16'd2; r.dest = 16'd5; r.bed = '0; r.carry = sfrs_pkg::VMAX;
        r.incis = 48'sd9000000;
        r.bh = 48'sd1000000; r.bhd = 48'sd999000; r.depth = '0;
        send_cell(r);
        // bedrock already below downstream
        r.idx = 16'd3; r.bh = -48'sd5000; r.bhd = 48'sd5000;
        send_cell(r);
        // outflux into a basin, then the outlet overflows
        r = '{idx: 16'd4, dest: 16'd6, to_basin: 1'b1, outlet: 1'b0, cap: '0,
              hill: 1'b1, carry: 48'sd800000, incis: '0, bed: '0,
              depth: sfrs_pkg::VMAX, bh: '0, bhd: '0};
        send_cell(r);
        r.idx = 16'd6; r.dest = 16'd6; r.to_basin = 0; r.outlet = 1; r.cap = 48'sd1000;
        send_cell(r);
        // same cell as its own target, then revisited
        send_cell(r);
        // negative outflux, extremes, indices at top of range
        r = '{idx: 16'hFFFF, dest: 16'hFFFF, to_basin: 1'b1, outlet: 1'b1,
              cap: sfrs_pkg::VMIN, hill: 1'b0, carry: sfrs_pkg::VMIN,
              incis: sfrs_pkg::VMIN, bed: sfrs_pkg::VMIN, depth: sfrs_pkg::VMIN,
              bh: sfrs_pkg::VMIN, bhd: sfrs_pkg::VMAX};
        send_cell(r);
        r.carry = sfrs_pkg::VMAX; r.incis = sfrs_pkg::VMAX; r.bed = sfrs_pkg::VMAX;
        r.depth = sfrs_pkg::VMAX; r.bh = sfrs_pkg::VMAX; r.bhd = sfrs_pkg::VMIN;
        r.cap = sfrs_pkg::VMAX; r.to_basin = 0;
        send_cell(r);
        r.hill = 1; r.carry = sfrs_pkg::VMIN;
        send_cell(r);
        for (int i = 0; i < 8; i++) send_cell(rand_cell(7));
    endtask

    task automatic test_random(int n, int span);
        repeat (n) send_cell(rand_cell(span));
    endtask

    // output stalled long while input keeps offering
    task automatic test_backpressure();
        hold_off <= 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off <= 0;
            end
            test_random(10, 15);
        join
    endtask

    initial begin
        area = sfrs_pkg::AREA_RST;
        for (int i = 0; i < sfrs_pkg::CELLS; i++) begin
            inflow_acc[i] = 0;
            basin_acc[i] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        send_idle_pct = 14; recv_idle_pct = 64;
        test_directed();
        drain();
        test_random(120, 15);
        drain();
        write_area(47'd0);
        test_random(30, 15);
        drain();
        write_area({47{1'b1}});
        send_idle_pct = 64; recv_idle_pct = 14;
        test_random(60, 31);
        drain();
        write_area(47'd65536);
        test_random(100, 15);
        drain();
        write_area(47'd1);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(40, 15);
        drain();
        write_area(sfrs_pkg::AREA_RST);
        test_backpressure();
        test_random(80, 63);
        drain();
        if (errors == 0) $display("sediment_flux_routing_step regression: pass");
        else $display("sediment_flux_routing_step regression: fail");
        $finish;
    end
endmodule
